>>> hw/rtl/ird_pkg.sv
// Shared constants, codes and types of the IMU rest detector.
package ird_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int FRAC_BITS = 16;
    localparam int TICK_W    = 20;
    localparam int DT_W      = 9;
    localparam int ALPHA_W   = FRAC_BITS + 1;

    // configuration register indexes
    localparam logic [2:0] REG_GYRO_TAU   = 3'd0;
    localparam logic [2:0] REG_ACCEL_TAU  = 3'd1;
    localparam logic [2:0] REG_RISE_TAU   = 3'd2;
    localparam logic [2:0] REG_FALL_TAU   = 3'd3;
    localparam logic [2:0] REG_GYRO_GATE  = 3'd4;
    localparam logic [2:0] REG_ACCEL_GATE = 3'd5;
    localparam logic [2:0] REG_RATE_GATE  = 3'd6;
    localparam logic [2:0] REG_DWELL      = 3'd7;

    // arithmetic unit operations
    localparam logic [1:0] OP_MUL  = 2'd0;
    localparam logic [1:0] OP_DIV  = 2'd1;
    localparam logic [1:0] OP_SQRT = 2'd2;

    localparam logic [4:0] MUL_STEPS  = 5'd20;
    localparam logic [4:0] DIV_STEPS  = 5'd25;
    localparam logic [4:0] SQRT_STEPS = 5'd21;

    typedef struct packed {
        logic       start;
        logic [1:0] op;
    } t_alu_req;

endpackage

>>> hw/rtl/ird_alu.sv
// Bit-serial arithmetic unit: shift-add multiply, restoring divide, square root.
module ird_alu (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ird_pkg::t_alu_req i_req,
    input  logic [41:0]       i_a,
    input  logic [20:0]       i_b,
    output logic              o_done,
    output logic [51:0]       o_res
);

    logic        r_busy;
    logic        r_done;
    logic [1:0]  r_op;
    logic [4:0]  r_cnt;
    logic [51:0] r_acc;
    logic [41:0] r_opa;
    logic [20:0] r_opb;

    logic [32:0] mul_sum;
    logic [21:0] div_t;
    logic        div_ge;
    logic [21:0] div_r;
    logic [24:0] sq_t;
    logic [24:0] sq_trial;
    logic        sq_ge;
    logic [24:0] sq_r;
    logic [4:0]  steps;

    always_comb begin
        mul_sum  = {1'b0, r_acc[51:20]} + (r_opb[0] ? {1'b0, r_opa[31:0]} : 33'd0);
        div_t    = {r_acc[20:0], r_opa[24]};
        div_ge   = div_t >= {1'b0, r_opb};
        div_r    = div_ge ? div_t - {1'b0, r_opb} : div_t;
        sq_t     = {r_acc[22:0], r_opa[41:40]};
        sq_trial = {2'b00, r_acc[51:31], 2'b01};
        sq_ge    = sq_t >= sq_trial;
        sq_r     = sq_ge ? sq_t - sq_trial : sq_t;
        case (r_op)
            ird_pkg::OP_MUL:  steps = ird_pkg::MUL_STEPS;
            ird_pkg::OP_DIV:  steps = ird_pkg::DIV_STEPS;
            default:          steps = ird_pkg::SQRT_STEPS;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_op   <= ird_pkg::OP_MUL;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_op   <= i_req.op;
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_acc  <= '0;
                r_opa  <= i_a;
                r_opb  <= i_b;
            end else if (r_busy) begin
                case (r_op)
                    ird_pkg::OP_MUL: begin
                        r_acc <= {mul_sum, r_acc[19:1]};
                        r_opb <= r_opb >> 1;
                    end
                    ird_pkg::OP_DIV: begin
                        r_acc[20:0]  <= div_r[20:0];
                        r_acc[45:21] <= {r_acc[44:21], div_ge};
                        r_opa        <= r_opa << 1;
                    end
                    default: begin
                        r_acc[22:0]  <= sq_r[22:0];
                        r_acc[51:31] <= {r_acc[50:31], sq_ge};
                        r_opa        <= r_opa << 2;
                    end
                endcase
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == steps - 5'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_comb begin
        case (r_op)
            ird_pkg::OP_MUL:  o_res = r_acc;
            ird_pkg::OP_DIV:  o_res = {27'd0, r_acc[45:21]};
            default:          o_res = {31'd0, r_acc[51:31]};
        endcase
    end

    assign o_done = r_done;

endmodule

>>> hw/rtl/imu_rest_detector_top.sv
// IMU rest detector: low-pass filters, deviation smoothing, gates and dwell timers.
//
//  channel   | direction | handshake              | payload
//  s_axis    | in        | tvalid/tready          | tdata 112b sample, tuser 2b
//  m_axis    | out       | tvalid/tready          | tdata 88b status
//  apb       | in        | psel/penable/pready    | paddr 6b, pwdata/prdata 64b
//
//  A normal sample runs up to four alpha divides (25 steps), twelve filter
//  multiplies and fifteen squares (20 steps each) and two square roots
//  (21 steps), all on the one bit-serial arithmetic unit.
//  A first sample or a gap restart loads the filters and goes straight to output.
//  One sample is in work at a time; the result register holds while m_axis stalls.
//  Reset clears the registers to their defaults and the detector to unprimed.
module imu_rest_detector_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z, interval_ticks, zero pad
    input  logic [111:0]  s_axis_tdata,
    // mode, rate_gate_enable
    input  logic [1:0]    s_axis_tuser,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // rest_now, still, holdoff_active, gyro_deviation, accel_deviation,
    // lpf_gyro_x, lpf_gyro_y, lpf_gyro_z, zero pad
    output logic [87:0]   m_axis_tdata,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [5:0]    paddr,
    input  logic [63:0]   pwdata,
    output logic [63:0]   prdata,
    output logic          pready
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_ALPHA   = 4'd1;
    localparam logic [3:0] S_ALPHA_W = 4'd2;
    localparam logic [3:0] S_LP      = 4'd3;
    localparam logic [3:0] S_LP_W    = 4'd4;
    localparam logic [3:0] S_DV      = 4'd5;
    localparam logic [3:0] S_DV_W    = 4'd6;
    localparam logic [3:0] S_SQ      = 4'd7;
    localparam logic [3:0] S_SQ_W    = 4'd8;
    localparam logic [3:0] S_RT      = 4'd9;
    localparam logic [3:0] S_RT_W    = 4'd10;
    localparam logic [3:0] S_FIN     = 4'd11;
    localparam logic [3:0] S_OUT     = 4'd12;

    // configuration
    logic [19:0] r_tau [4];
    logic [31:0] r_gate [3];
    logic [39:0] r_dwell;

    // sequencer and state
    logic [3:0]  r_state;
    logic [3:0]  r_idx;
    logic [15:0] r_smp [6];
    logic [8:0]  r_dt;
    logic        r_rge;
    logic [16:0] r_alpha [4];
    logic [31:0] r_lp [6];
    logic [31:0] r_dv [6];
    logic [41:0] r_sum [3];
    logic        r_neg;
    logic        r_quiet;
    logic        r_motion;
    logic        r_primed;
    logic        r_rest;
    logic        r_still;
    logic [19:0] r_stimer;
    logic [19:0] r_htimer;
    logic [15:0] r_mag [2];
    logic        r_ovalid;
    logic [87:0] r_odata;

    ird_pkg::t_alu_req alu_req;
    logic [41:0] alu_a;
    logic [20:0] alu_b;
    logic        alu_done;
    logic [51:0] alu_res;

    logic        cfg_wr;
    logic        in_acc;
    logic [15:0] in_smp [6];
    logic [19:0] hold;
    logic [19:0] holdoff;

    logic [2:0]  u;
    logic [19:0] tau_sel;
    logic [20:0] den;
    logic [31:0] tg;
    logic [32:0] lp_diff;
    logic [32:0] lp_neg;
    logic [31:0] lp_mag;
    logic [16:0] alpha_lp;
    logic [31:0] sm;
    logic        fall;
    logic [32:0] d2;
    logic [32:0] d2_neg;
    logic [31:0] d2_mag;
    logic [51:0] rnd;
    logic [31:0] step_val;
    logic [31:0] n_lp;
    logic [31:0] n_dv;
    logic [3:0]  idx_m6;
    logic [3:0]  k;
    logic [3:0]  k3;
    logic [1:0]  kk;
    logic [31:0] lp_sel;
    logic [31:0] lp_abs;
    logic [15:0] gate_val;
    logic [19:0] sq_q;
    logic [1:0]  sum_idx;
    logic [41:0] sum_sel;
    logic [16:0] root_sh;
    logic [20:0] st_sum;
    logic [19:0] n_stimer;

    assign pready        = 1'b1;
    assign cfg_wr        = psel & penable & pwrite & pready;
    assign s_axis_tready = r_state == S_IDLE;
    assign in_acc        = s_axis_tvalid & s_axis_tready;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign hold          = r_dwell[19:0];
    assign holdoff       = r_dwell[39:20];

    always_comb begin
        for (int i = 0; i < 6; i++) begin
            in_smp[i] = s_axis_tdata[16*i +: 16];
        end
    end

    always_comb begin
        case (paddr[5:3])
            ird_pkg::REG_GYRO_TAU:   prdata = {44'd0, r_tau[0]};
            ird_pkg::REG_ACCEL_TAU:  prdata = {44'd0, r_tau[1]};
            ird_pkg::REG_RISE_TAU:   prdata = {44'd0, r_tau[2]};
            ird_pkg::REG_FALL_TAU:   prdata = {44'd0, r_tau[3]};
            ird_pkg::REG_GYRO_GATE:  prdata = {32'd0, r_gate[0]};
            ird_pkg::REG_ACCEL_GATE: prdata = {32'd0, r_gate[1]};
            ird_pkg::REG_RATE_GATE:  prdata = {32'd0, r_gate[2]};
            default:                 prdata = {24'd0, r_dwell};
        endcase
    end

    // datapath around the arithmetic unit
    always_comb begin
        u        = r_idx[2:0];
        tau_sel  = r_tau[r_idx[1:0]];
        den      = {1'b0, tau_sel} + {12'd0, r_dt};
        tg       = {r_smp[u], 16'h0000};
        lp_diff  = {tg[31], tg} - {r_lp[u][31], r_lp[u]};
        lp_neg   = -lp_diff;
        lp_mag   = lp_diff[32] ? lp_neg[31:0] : lp_diff[31:0];
        alpha_lp = (u < 3'd3) ? r_alpha[0] : r_alpha[1];
        sm       = r_dv[u];
        fall     = lp_mag < sm;
        d2       = {1'b0, lp_mag} - {1'b0, sm};
        d2_neg   = -d2;
        d2_mag   = d2[32] ? d2_neg[31:0] : d2[31:0];
        rnd      = alu_res + 52'h8000;
        step_val = rnd[47:16];
        n_lp     = r_neg ? r_lp[u] - step_val : r_lp[u] + step_val;
        n_dv     = r_neg ? sm - step_val : sm + step_val;

        idx_m6   = r_idx - 4'd6;
        k        = r_idx - 4'd9;
        k3       = k - 4'd3;
        kk       = (k < 4'd3) ? k[1:0] : k3[1:0];
        lp_sel   = r_lp[idx_m6[1:0]];
        lp_abs   = lp_sel[31] ? -lp_sel : lp_sel;
        gate_val = (k < 4'd3) ? r_gate[kk][15:0] : r_gate[kk][31:16];
        if (r_idx < 4'd6) begin
            sq_q = r_dv[u][31:12];
        end else if (r_idx < 4'd9) begin
            sq_q = lp_abs[31:12];
        end else begin
            sq_q = {gate_val, 4'h0};
        end
        if (r_idx < 4'd3) begin
            sum_idx = 2'd0;
        end else if (r_idx < 4'd6) begin
            sum_idx = 2'd1;
        end else begin
            sum_idx = 2'd2;
        end
        if (kk == 2'd2) begin
            sum_sel = r_rge ? r_sum[2] : 42'd0;
        end else begin
            sum_sel = r_sum[kk];
        end
        root_sh  = alu_res[20:4];
        st_sum   = {1'b0, r_stimer} + {12'd0, r_dt};
        n_stimer = st_sum[20] ? {20{1'b1}} : st_sum[19:0];

        alu_req.start = 1'b0;
        alu_req.op    = ird_pkg::OP_MUL;
        alu_a         = '0;
        alu_b         = '0;
        case (r_state)
            S_ALPHA: begin
                alu_req.start = den != 21'd0;
                alu_req.op    = ird_pkg::OP_DIV;
                alu_a         = {17'd0, r_dt, 16'h0000};
                alu_b         = den;
            end
            S_LP: begin
                alu_req.start = 1'b1;
                alu_a         = {10'd0, lp_mag};
                alu_b         = {4'd0, alpha_lp};
            end
            S_DV: begin
                alu_req.start = 1'b1;
                alu_a         = {10'd0, d2_mag};
                alu_b         = {4'd0, fall ? r_alpha[3] : r_alpha[2]};
            end
            S_SQ: begin
                alu_req.start = 1'b1;
                alu_a         = {22'd0, sq_q};
                alu_b         = {1'b0, sq_q};
            end
            S_RT: begin
                alu_req.start = 1'b1;
                alu_req.op    = ird_pkg::OP_SQRT;
                alu_a         = r_sum[r_idx[0]];
            end
            default: begin
                alu_req.start = 1'b0;
            end
        endcase
    end

    ird_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (alu_req),
        .i_a     (alu_a),
        .i_b     (alu_b),
        .o_done  (alu_done),
        .o_res   (alu_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tau[0]  <= 20'd500;
            r_tau[1]  <= 20'd2000;
            r_tau[2]  <= 20'd3000;
            r_tau[3]  <= 20'd500;
            r_gate[0] <= '0;
            r_gate[1] <= '0;
            r_gate[2] <= '0;
            r_dwell   <= '0;
        end else if (cfg_wr) begin
            case (paddr[5:3])
                ird_pkg::REG_GYRO_TAU:   r_tau[0]  <= pwdata[19:0];
                ird_pkg::REG_ACCEL_TAU:  r_tau[1]  <= pwdata[19:0];
                ird_pkg::REG_RISE_TAU:   r_tau[2]  <= pwdata[19:0];
                ird_pkg::REG_FALL_TAU:   r_tau[3]  <= pwdata[19:0];
                ird_pkg::REG_GYRO_GATE:  r_gate[0] <= pwdata[31:0];
                ird_pkg::REG_ACCEL_GATE: r_gate[1] <= pwdata[31:0];
                ird_pkg::REG_RATE_GATE:  r_gate[2] <= pwdata[31:0];
                default:                 r_dwell   <= pwdata[39:0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_idx    <= '0;
            r_primed <= 1'b0;
            r_rest   <= 1'b0;
            r_still  <= 1'b0;
            r_stimer <= '0;
            r_htimer <= '0;
            r_mag[0] <= '0;
            r_mag[1] <= '0;
            r_ovalid <= 1'b0;
        end else begin
            // drop a taken result unless a new one is loaded in this cycle
            if (r_ovalid && m_axis_tready && r_state != S_OUT) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        for (int i = 0; i < 6; i++) begin
                            r_smp[i] <= in_smp[i];
                        end
                        r_dt     <= s_axis_tdata[104:96];
                        r_rge    <= s_axis_tuser[1];
                        r_idx    <= '0;
                        r_quiet  <= 1'b1;
                        r_motion <= 1'b0;
                        for (int i = 0; i < 3; i++) begin
                            r_sum[i] <= '0;
                        end
                        if (s_axis_tuser[0] || !r_primed) begin
                            // load the filters straight from the sample
                            for (int i = 0; i < 6; i++) begin
                                r_lp[i] <= {in_smp[i], 16'h0000};
                                r_dv[i] <= '0;
                            end
                            r_primed <= 1'b1;
                            r_stimer <= '0;
                            if (s_axis_tuser[0]) begin
                                r_rest   <= 1'b0;
                                r_still  <= 1'b0;
                                r_htimer <= holdoff;
                            end else begin
                                r_mag[0] <= '0;
                                r_mag[1] <= '0;
                                r_rest   <= 1'b1;
                                r_still  <= hold == 20'd0;
                                r_htimer <= '0;
                            end
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_ALPHA;
                        end
                    end
                end
                S_ALPHA: begin
                    if (den == 21'd0) begin
                        r_alpha[r_idx[1:0]] <= 17'h10000;
                        r_idx   <= (r_idx == 4'd3) ? 4'd0 : r_idx + 4'd1;
                        r_state <= (r_idx == 4'd3) ? S_LP : S_ALPHA;
                    end else begin
                        r_state <= S_ALPHA_W;
                    end
                end
                S_ALPHA_W: begin
                    if (alu_done) begin
                        r_alpha[r_idx[1:0]] <= alu_res[16:0];
                        r_idx   <= (r_idx == 4'd3) ? 4'd0 : r_idx + 4'd1;
                        r_state <= (r_idx == 4'd3) ? S_LP : S_ALPHA;
                    end
                end
                S_LP: begin
                    r_neg   <= lp_diff[32];
                    r_state <= S_LP_W;
                end
                S_LP_W: begin
                    if (alu_done) begin
                        r_lp[u] <= n_lp;
                        r_state <= S_DV;
                    end
                end
                S_DV: begin
                    r_neg   <= d2[32];
                    r_state <= S_DV_W;
                end
                S_DV_W: begin
                    if (alu_done) begin
                        r_dv[u] <= n_dv;
                        r_idx   <= (r_idx == 4'd5) ? 4'd0 : r_idx + 4'd1;
                        r_state <= (r_idx == 4'd5) ? S_SQ : S_LP;
                    end
                end
                S_SQ: begin
                    r_state <= S_SQ_W;
                end
                S_SQ_W: begin
                    if (alu_done) begin
                        if (r_idx < 4'd9) begin
                            r_sum[sum_idx] <= r_sum[sum_idx] + alu_res[41:0];
                        end else if (k < 4'd3) begin
                            r_quiet <= r_quiet & (sum_sel < alu_res[41:0]);
                        end else begin
                            r_motion <= r_motion | (sum_sel > alu_res[41:0]);
                        end
                        r_idx   <= (r_idx == 4'd14) ? 4'd0 : r_idx + 4'd1;
                        r_state <= (r_idx == 4'd14) ? S_RT : S_SQ;
                    end
                end
                S_RT: begin
                    r_state <= S_RT_W;
                end
                S_RT_W: begin
                    if (alu_done) begin
                        r_mag[r_idx[0]] <= root_sh[16] ? 16'hFFFF : root_sh[15:0];
                        r_idx   <= r_idx[0] ? 4'd0 : r_idx + 4'd1;
                        r_state <= r_idx[0] ? S_FIN : S_RT;
                    end
                end
                S_FIN: begin
                    r_rest <= r_quiet;
                    if (r_motion) begin
                        r_stimer <= '0;
                        r_still  <= 1'b0;
                        r_htimer <= holdoff;
                    end else begin
                        if (r_quiet) begin
                            r_stimer <= n_stimer;
                            if (n_stimer >= hold) begin
                                r_still <= 1'b1;
                            end
                        end
                        r_htimer <= (r_htimer > {11'd0, r_dt}) ? r_htimer - {11'd0, r_dt}
                                                                 : 20'd0;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_ovalid || m_axis_tready) begin
                        r_odata  <= {5'd0, r_lp[2][31:16], r_lp[1][31:16], r_lp[0][31:16],
                                     r_mag[1], r_mag[0], r_htimer != 20'd0, r_still, r_rest};
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

>>> hw/rtl/ird_checker.sv
// Port-level checks of the IMU rest detector and their binding.
module ird_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [87:0] m_axis_tdata
);

    // one request in work at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while a request is in work");

    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
        else $error("result appeared too early after a request");

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    a_data_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");

endmodule

bind imu_rest_detector_top ird_checker u_ird_checker (.*);
